[hdl/dtv_pkg.sv]
// ============================================================================
// dtv_pkg: shared types, constants and the sine table of the tone voice
// Channel payloads, controller commands and status, register indexes and
// the Q1.23 sine table built at elaboration.
// ============================================================================
package dtv_pkg;

    // Sizing
    localparam int SINE_ENTRIES = 1024;
    localparam int MIX_WIDTH    = 24;
    localparam int SINE_BITS    = $clog2(SINE_ENTRIES);
    localparam int WAVE_WIDTH   = 24;
    localparam int PROD_WIDTH   = 48;
    localparam int VOICE_SHIFT  = PROD_WIDTH - MIX_WIDTH;

    // Register indexes
    localparam int CFG_INDEX_WIDTH = 3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PHASE_STEP   = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_WAVEFORM     = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_AMPLITUDE    = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DECAY_FACTOR = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_NOTE_LENGTH  = 3'd4;

    // Register reset values
    localparam logic [31:0] PHASE_STEP_RST   = 32'd39370534;
    localparam logic [1:0]  WAVEFORM_RST     = 2'd0;
    localparam logic [15:0] AMPLITUDE_RST    = 16'd13107;
    localparam logic [23:0] DECAY_FACTOR_RST = 24'd16775119;
    localparam logic [23:0] NOTE_LENGTH_RST  = 24'd0;

    // Waveform codes; the unused fourth code plays as sine
    localparam logic [1:0] WAVE_SINE     = 2'd0;
    localparam logic [1:0] WAVE_TRIANGLE = 2'd1;
    localparam logic [1:0] WAVE_SQUARE   = 2'd2;

    // Opcodes
    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_TRIGGER = 1'b1;

    localparam logic signed [WAVE_WIDTH-1:0] WAVE_MAX = 24'sd8388607;
    localparam logic [23:0] ENV_FULL = 24'hFF_FFFF;

    // Q30 angle constants
    localparam logic [63:0] PI_Q30      = 64'd3373259426;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;

    typedef struct packed {
        logic                        opcode;
        logic signed [MIX_WIDTH-1:0] left_in;
        logic signed [MIX_WIDTH-1:0] right_in;
    } dtv_req_t;

    typedef struct packed {
        logic signed [MIX_WIDTH-1:0] left_out;
        logic signed [MIX_WIDTH-1:0] right_out;
        logic                        voice_active;
    } dtv_rsp_t;

    typedef struct packed {
        logic capture;   // latch the accepted beat
        logic trigger;   // restart envelope and count
        logic pass;      // result is the mix unchanged
        logic start;     // gain product and sine read
        logic shape;     // select the waveform sample
        logic mult;      // wave times gain
        logic mix;       // saturated add and state advance
        logic load_out;  // move result into the output register
    } dtv_cmd_t;

    typedef struct packed {
        logic opcode;
        logic active;
    } dtv_sts_t;

    typedef logic signed [WAVE_WIDTH-1:0] sine_tab_t [SINE_ENTRIES];

    // One table entry: Taylor series in Q30 over the first quadrant
    function automatic logic signed [WAVE_WIDTH-1:0] sine_entry(input int k);
        logic [63:0]        x;
        logic [63:0]        xx;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic               neg;
        x   = (64'(k) * TWO_PI_Q30) / 64'(SINE_ENTRIES);
        neg = 1'b0;
        if (x >= PI_Q30)
        begin
            neg = 1'b1;
            x   = x - PI_Q30;
        end
        if (x > HALF_PI_Q30)
            x = PI_Q30 - x;
        xx   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        term = ((term * xx) >> 30) / 64'd6;
        sum  = sum - $signed(term);
        term = ((term * xx) >> 30) / 64'd20;
        sum  = sum + $signed(term);
        term = ((term * xx) >> 30) / 64'd42;
        sum  = sum - $signed(term);
        term = ((term * xx) >> 30) / 64'd72;
        sum  = sum + $signed(term);
        term = ((term * xx) >> 30) / 64'd110;
        sum  = sum - $signed(term);
        term = ((term * xx) >> 30) / 64'd156;
        sum  = sum + $signed(term);
        term = ((term * xx) >> 30) / 64'd210;
        sum  = sum - $signed(term);
        term = ((term * xx) >> 30) / 64'd272;
        sum  = sum + $signed(term);
        if (sum < 0)
            sum = 64'sd0;
        sum = (sum + 64'sd64) >>> 7;
        if (sum > 64'(WAVE_MAX))
            sum = 64'(WAVE_MAX);
        if (neg)
            sum = -sum;
        return sum[WAVE_WIDTH-1:0];
    endfunction

    function automatic sine_tab_t build_sine_tab();
        sine_tab_t t;
        for (int k = 0; k < SINE_ENTRIES; k++)
            t[k] = sine_entry(k);
        return t;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

[hdl/decaying_tone_voice_core.sv]
// ============================================================================
// decaying_tone_voice_core: one synthesizer voice mixed into a stereo stream
// Sequencer plus datapath: NCO tone with decaying envelope, saturating add.
// ============================================================================
// Usage:
//   req carries one beat: a sample tick with a left/right mix pair, or a
//   trigger that restarts the envelope at full scale and the note count.
//   req is taken when req_valid is high and req_stall low; rsp moves the
//   same way on rsp_valid/rsp_stall, one result beat for every request.
//   Registers are written over cfg_* (cfg_ready is always high); the user
//   must write them only while the voice is idle, and the block does not
//   enforce this; indexes beyond note_length are dropped.
//   An active tick walks decide (sine read and gain), wave select, product,
//   mix and output load before rsp_valid rises; a trigger or a tick after
//   the note has ended goes from decide straight to output load. One item
//   is in work at a time, so req_stall stays high until the walk is done.
//   The output register holds the last result, so the next request is
//   taken while rsp waits; a stalled result holds and the sequencer waits
//   before loading the following one.
//   Reset clears phase, count and envelope to zero, loads the default
//   registers and empties the output; the voice stays silent until a
//   trigger arrives and note_length is nonzero.
module decaying_tone_voice_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  dtv_pkg::dtv_req_t                   req,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output dtv_pkg::dtv_rsp_t                   rsp,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dtv_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [31:0]                         cfg_data
);

    dtv_pkg::dtv_cmd_t cmd;
    dtv_pkg::dtv_sts_t sts;

    assign cfg_ready = 1'b1;

    dtv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    dtv_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .rsp       (rsp),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

[hdl/dtv_ctrl.sv]
// ============================================================================
// dtv_ctrl: sequencer of the tone voice
// Takes one beat at a time, steps the datapath through gain, wave, product
// and mix (triggers and ended notes skip to output) and owns the output valid.
// ============================================================================
module dtv_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    input  dtv_pkg::dtv_sts_t sts,
    output dtv_pkg::dtv_cmd_t cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_SHAPE  = 3'd2;
    localparam logic [2:0] S_MULT   = 3'd3;
    localparam logic [2:0] S_MIX    = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && !rsp_stall)
            rsp_valid_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                priority if (sts.opcode == dtv_pkg::OP_TRIGGER)
                begin
                    cmd.trigger = 1'b1;
                    cmd.pass    = 1'b1;
                    state_next  = S_OUT;
                end
                else if (!sts.active)
                begin
                    cmd.pass   = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.start  = 1'b1;
                    state_next = S_SHAPE;
                end
            end
            S_SHAPE:
            begin
                cmd.shape  = 1'b1;
                state_next = S_MULT;
            end
            S_MULT:
            begin
                cmd.mult   = 1'b1;
                state_next = S_MIX;
            end
            S_MIX:
            begin
                cmd.mix    = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // hold until the output register is free or being drained
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    cmd.load_out   = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

[hdl/dtv_dp.sv]
// ============================================================================
// dtv_dp: datapath of the tone voice
// Configuration registers, phase/envelope/count state, sine ROM, the three
// multipliers and the saturating mix, each step registered.
// ============================================================================
module dtv_dp (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [dtv_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [31:0]                           cfg_data,
    input  dtv_pkg::dtv_req_t                     req,
    output dtv_pkg::dtv_rsp_t                     rsp,
    input  dtv_pkg::dtv_cmd_t                     cmd,
    output dtv_pkg::dtv_sts_t                     sts
);

    localparam int MW = dtv_pkg::MIX_WIDTH;
    localparam int WW = dtv_pkg::WAVE_WIDTH;
    localparam int PW = dtv_pkg::PROD_WIDTH;
    localparam int SB = dtv_pkg::SINE_BITS;

    // configuration
    logic [31:0] phase_step_reg;
    logic [1:0]  waveform_reg;
    logic [15:0] amplitude_reg;
    logic [23:0] decay_factor_reg;
    logic [23:0] note_length_reg;

    // voice state
    logic [31:0] phase_reg;
    logic [23:0] count_reg;
    logic [23:0] env_reg;

    // work registers
    dtv_pkg::dtv_req_t          item_reg;
    logic [23:0]                gain_reg;
    logic signed [WW-1:0]       sine_reg;
    logic signed [WW-1:0]       wave_reg;
    logic signed [WW-1:0]       wave_next;
    logic signed [PW-1:0]       prod_reg;
    dtv_pkg::dtv_rsp_t          res_reg;
    dtv_pkg::dtv_rsp_t          res_next;
    dtv_pkg::dtv_rsp_t          rsp_reg;

    logic [39:0]                gain_full;
    logic [47:0]                env_full;
    logic signed [PW:0]         prod_full;
    logic signed [25:0]         tri_d;
    logic signed [25:0]         tri_abs;
    logic signed [25:0]         tri_s;
    logic signed [MW-1:0]       voice;
    logic signed [MW:0]         sum_l;
    logic signed [MW:0]         sum_r;

    assign sts.opcode = item_reg.opcode;
    assign sts.active = (count_reg < note_length_reg);
    assign rsp        = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg   <= dtv_pkg::PHASE_STEP_RST;
            waveform_reg     <= dtv_pkg::WAVEFORM_RST;
            amplitude_reg    <= dtv_pkg::AMPLITUDE_RST;
            decay_factor_reg <= dtv_pkg::DECAY_FACTOR_RST;
            note_length_reg  <= dtv_pkg::NOTE_LENGTH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dtv_pkg::CFG_PHASE_STEP:   phase_step_reg   <= cfg_data;
                dtv_pkg::CFG_WAVEFORM:     waveform_reg     <= cfg_data[1:0];
                dtv_pkg::CFG_AMPLITUDE:    amplitude_reg    <= cfg_data[15:0];
                dtv_pkg::CFG_DECAY_FACTOR: decay_factor_reg <= cfg_data[23:0];
                dtv_pkg::CFG_NOTE_LENGTH:  note_length_reg  <= cfg_data[23:0];
                default:                   ;
            endcase
        end
    end

    assign gain_full = env_reg * amplitude_reg;
    assign env_full  = env_reg * decay_factor_reg;
    assign prod_full = wave_reg * $signed({1'b0, gain_reg});

    // triangle: |2*(phase>>8) - 2^24| - 2^23, capped at full scale
    always_comb
    begin
        tri_d   = $signed({1'b0, phase_reg[31:8], 1'b0}) - 26'sd16777216;
        tri_abs = (tri_d < 0) ? -tri_d : tri_d;
        tri_s   = tri_abs - 26'sd8388608;
        if (tri_s > 26'(dtv_pkg::WAVE_MAX))
            tri_s = 26'(dtv_pkg::WAVE_MAX);
    end

    always_comb
    begin
        unique case (waveform_reg)
            dtv_pkg::WAVE_TRIANGLE: wave_next = tri_s[WW-1:0];
            dtv_pkg::WAVE_SQUARE:
                wave_next = phase_reg[31] ? -dtv_pkg::WAVE_MAX : dtv_pkg::WAVE_MAX;
            default:                wave_next = sine_reg;
        endcase
    end

    // floor(prod / 2^VOICE_SHIFT) is the top MIX_WIDTH bits
    assign voice = prod_reg[PW-1:dtv_pkg::VOICE_SHIFT];
    assign sum_l = {item_reg.left_in[MW-1], item_reg.left_in} + {voice[MW-1], voice};
    assign sum_r = {item_reg.right_in[MW-1], item_reg.right_in} + {voice[MW-1], voice};

    function automatic logic signed [MW-1:0] sat(input logic signed [MW:0] v);
        logic signed [MW-1:0] r;
        r = v[MW-1:0];
        if (v[MW] != v[MW-1])
            r = v[MW] ? {1'b1, {(MW-1){1'b0}}} : {1'b0, {(MW-1){1'b1}}};
        return r;
    endfunction

    always_comb
    begin
        res_next = res_reg;
        priority if (cmd.pass)
        begin
            res_next.left_out     = item_reg.left_in;
            res_next.right_out    = item_reg.right_in;
            res_next.voice_active = 1'b0;
        end
        else if (cmd.mix)
        begin
            res_next.left_out     = sat(sum_l);
            res_next.right_out    = sat(sum_r);
            res_next.voice_active = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            count_reg <= '0;
            env_reg   <= '0;
        end
        else if (cmd.trigger)
        begin
            env_reg   <= dtv_pkg::ENV_FULL;
            count_reg <= '0;
        end
        else if (cmd.mix)
        begin
            phase_reg <= phase_reg + phase_step_reg;
            env_reg   <= env_full[47:24];
            count_reg <= count_reg + 24'd1;
        end
    end

    // sine ROM, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.start)
            sine_reg <= dtv_pkg::SINE_TAB[phase_reg[31 -: SB]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            item_reg <= req;
        if (cmd.start)
            gain_reg <= gain_full[39:16];
        if (cmd.shape)
            wave_reg <= wave_next;
        if (cmd.mult)
            prod_reg <= prod_full[PW-1:0];
        res_reg <= res_next;
        if (cmd.load_out)
            rsp_reg <= res_reg;
    end

endmodule

[hdl/dtv_checker.sv]
// ============================================================================
// dtv_checker: port-level checks of the tone voice
// Tracks beats in flight and watches reset, stall and output behavior.
// ============================================================================
module dtv_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                req_valid,
    input logic                                req_stall,
    input logic                                rsp_valid,
    input logic                                rsp_stall,
    input dtv_pkg::dtv_rsp_t                   rsp
);

    logic       req_fire;
    logic       rsp_fire;
    logic [1:0] inflight_reg;
    logic [1:0] inflight_next;

    assign req_fire = req_valid && !req_stall;
    assign rsp_fire = rsp_valid && !rsp_stall;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (req_fire && !rsp_fire)
            inflight_next = inflight_reg + 2'd1;
        else if (rsp_fire && !req_fire)
            inflight_next = inflight_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inflight_reg <= '0;
        else
            inflight_reg <= inflight_next;
    end

    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !rsp_valid)
        else $error("rsp_valid high during reset");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> req_stall)
        else $error("second beat taken while one is in work");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled result changed");

    a_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        (inflight_reg != 2'd3) && (!rsp_valid || inflight_reg != 2'd0))
        else $error("result beats do not match request beats");

endmodule

bind decaying_tone_voice_core dtv_checker u_dtv_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

[dv/decaying_tone_voice_core_test.sv]
`timescale 1ns / 1ps
// ============================================================================
// decaying_tone_voice_core_test: self-checking bench for the tone voice core
// Drives tick and trigger beats with random bursts and receiver stalls,
// reprograms the voice between phases, and checks every result beat against
// an in-bench model of the tone, envelope, note count and saturating mix.
// ============================================================================
module decaying_tone_voice_core_test;

    localparam int MW = dtv_pkg::MIX_WIDTH;
    localparam int IW = dtv_pkg::CFG_INDEX_WIDTH;
    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam logic signed [MW-1:0] MIX_MAX = {1'b0, {(MW-1){1'b1}}};
    localparam logic signed [MW-1:0] MIX_MIN = {1'b1, {(MW-1){1'b0}}};
    localparam logic [1:0] WAVE_SPARE = 2'd3;
    localparam logic [IW-1:0] CFG_SPARE = dtv_pkg::CFG_NOTE_LENGTH + 1'b1;
    localparam int CFG_TOP = (1 << IW) - 1;

    typedef enum logic [1:0] {FLOW_OPEN, FLOW_LIGHT, FLOW_HEAVY, FLOW_PERIODIC} flow_mode_t;

    class voice_scoreboard;
        int                 sine_lut [dtv_pkg::SINE_ENTRIES];
        logic [31:0]        phase_step;
        logic [1:0]         waveform;
        logic [15:0]        amplitude;
        logic [23:0]        decay_factor;
        logic [23:0]        note_length;
        logic [31:0]        phase;
        logic [23:0]        count;
        logic [23:0]        envelope;
        dtv_pkg::dtv_rsp_t  expected_mix [$];
        int                 mismatches;

        function new();
            for (int k = 0; k < dtv_pkg::SINE_ENTRIES; k++)
                sine_lut[k] = series_sine(k);
            phase_step   = dtv_pkg::PHASE_STEP_RST;
            waveform     = dtv_pkg::WAVEFORM_RST;
            amplitude    = dtv_pkg::AMPLITUDE_RST;
            decay_factor = dtv_pkg::DECAY_FACTOR_RST;
            note_length  = dtv_pkg::NOTE_LENGTH_RST;
            phase        = '0;
            count        = '0;
            envelope     = '0;
            mismatches   = 0;
        endfunction

        // Q30 Taylor series on the first quadrant, folded by symmetry
        static function int series_sine(int k);
            logic [63:0] x;
            logic [63:0] xx;
            logic [63:0] term;
            longint      sum;
            bit          neg;
            x   = (64'(k) * dtv_pkg::TWO_PI_Q30) / 64'(dtv_pkg::SINE_ENTRIES);
            neg = (x >= dtv_pkg::PI_Q30);
            if (neg)
                x = x - dtv_pkg::PI_Q30;
            if (x > dtv_pkg::HALF_PI_Q30)
                x = dtv_pkg::PI_Q30 - x;
            xx   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int n = 2; n <= 16; n += 2)
            begin
                term = ((term * xx) >> 30) / 64'(n * (n + 1));
                if ((n / 2) % 2 == 1)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            if (sum < 0)
                sum = 0;
            sum = (sum + 64) / 128;
            if (sum > longint'(dtv_pkg::WAVE_MAX))
                sum = longint'(dtv_pkg::WAVE_MAX);
            return neg ? -int'(sum) : int'(sum);
        endfunction

        static function longint clip_mix(longint v);
            longint hi;
            longint lo;
            hi = (longint'(1) << (MW - 1)) - 1;
            lo = -hi - 1;
            if (v > hi)
                return hi;
            if (v < lo)
                return lo;
            return v;
        endfunction

        function longint tone_sample();
            longint ramp;
            case (waveform)
                dtv_pkg::WAVE_TRIANGLE:
                begin
                    ramp = 2 * longint'(phase >> 8) - (longint'(1) << 24);
                    if (ramp < 0)
                        ramp = -ramp;
                    ramp = ramp - (longint'(1) << 23);
                    return (ramp > longint'(dtv_pkg::WAVE_MAX)) ?
                           longint'(dtv_pkg::WAVE_MAX) : ramp;
                end
                dtv_pkg::WAVE_SQUARE:
                    return phase[31] ? -longint'(dtv_pkg::WAVE_MAX) :
                                       longint'(dtv_pkg::WAVE_MAX);
                default:
                    return sine_lut[(64'(phase) * 64'(dtv_pkg::SINE_ENTRIES)) >> 32];
            endcase
        endfunction

        function void load_register(logic [IW-1:0] idx, logic [31:0] val);
            case (idx)
                dtv_pkg::CFG_PHASE_STEP:   phase_step   = val;
                dtv_pkg::CFG_WAVEFORM:     waveform     = val[1:0];
                dtv_pkg::CFG_AMPLITUDE:    amplitude    = val[15:0];
                dtv_pkg::CFG_DECAY_FACTOR: decay_factor = val[23:0];
                dtv_pkg::CFG_NOTE_LENGTH:  note_length  = val[23:0];
                default:                   ;
            endcase
        endfunction

        function void accept_request(dtv_pkg::dtv_req_t item);
            dtv_pkg::dtv_rsp_t want;
            longint            left;
            longint            right;
            longint            gain;
            longint            voice;
            left              = longint'(item.left_in);
            right             = longint'(item.right_in);
            want.voice_active = 1'b0;
            if (item.opcode == dtv_pkg::OP_TRIGGER)
            begin
                envelope = dtv_pkg::ENV_FULL;
                count    = '0;
            end
            else if (count < note_length)
            begin
                gain  = (longint'(envelope) * longint'(amplitude)) >>> 16;
                voice = (tone_sample() * gain) >>> dtv_pkg::VOICE_SHIFT;
                left  = clip_mix(left + voice);
                right = clip_mix(right + voice);
                want.voice_active = 1'b1;
                // advance phase, decay the envelope, count the sample
                phase    = phase + phase_step;
                envelope = 24'((64'(envelope) * 64'(decay_factor)) >> 24);
                count    = count + 1'b1;
            end
            want.left_out  = left[MW-1:0];
            want.right_out = right[MW-1:0];
            expected_mix.push_back(want);
        endfunction

        function void check_result(dtv_pkg::dtv_rsp_t got);
            dtv_pkg::dtv_rsp_t want;
            if (expected_mix.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%t result beat with nothing expected: L=%0d R=%0d active=%0b",
                             $realtime, got.left_out, got.right_out, got.voice_active);
                return;
            end
            want = expected_mix.pop_front();
            if (got.left_out !== want.left_out || got.right_out !== want.right_out ||
                got.voice_active !== want.voice_active)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%t mix mismatch: expected L=%0d R=%0d active=%0b, %s",
                             $realtime, want.left_out, want.right_out, want.voice_active,
                             $sformatf("got L=%0d R=%0d active=%0b",
                                       got.left_out, got.right_out, got.voice_active));
            end
        endfunction

        function int pending();
            return expected_mix.size();
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              req_valid = 1'b0;
    logic              req_stall;
    dtv_pkg::dtv_req_t req = '0;
    logic              rsp_valid;
    logic              rsp_stall = 1'b0;
    dtv_pkg::dtv_rsp_t rsp;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [IW-1:0]     cfg_index = '0;
    logic [31:0]       cfg_data = '0;

    int unsigned     cycle_count = 0;
    flow_mode_t      flow_mode = FLOW_OPEN;
    int unsigned     burst_left = 0;
    voice_scoreboard sb;

    decaying_tone_voice_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // Receiver: drive rsp_stall from one of four stall patterns, picked anew at random
    always @(posedge clk)
    begin
        if (cycle_count % 150 == 149)
            flow_mode <= flow_mode_t'($urandom_range(0, 3));
        case (flow_mode)
            FLOW_OPEN:  rsp_stall <= 1'b0;
            FLOW_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            FLOW_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 7);
            default:    rsp_stall <= (cycle_count % 7) < 3;
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.load_register(cfg_index, cfg_data);
            if (req_valid && !req_stall)
                sb.accept_request(req);
            if (rsp_valid && !rsp_stall)
                sb.check_result(rsp);
        end
    end

    function automatic dtv_pkg::dtv_req_t make_req(logic op, logic signed [MW-1:0] l,
                                                   logic signed [MW-1:0] r);
        dtv_pkg::dtv_req_t item;
        item.opcode   = op;
        item.left_in  = l;
        item.right_in = r;
        return item;
    endfunction

    function automatic logic signed [MW-1:0] rand_mix();
        case ($urandom_range(0, 11))
            0:       return MIX_MAX;
            1:       return MIX_MIN;
            2:       return '0;
            3:       return '1;
            default: return MW'($urandom());
        endcase
    endfunction

    // Hold the write until the port takes it; caller drops cfg_valid
    task automatic cfg_write(input logic [IW-1:0] idx, input logic [31:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic load_voice(input logic [31:0] step, input logic [1:0] shape,
                              input logic [15:0] gain, input logic [23:0] decay,
                              input logic [23:0] length);
        cfg_write(dtv_pkg::CFG_PHASE_STEP, step);
        cfg_write(dtv_pkg::CFG_WAVEFORM, 32'(shape));
        cfg_write(dtv_pkg::CFG_AMPLITUDE, 32'(gain));
        cfg_write(dtv_pkg::CFG_DECAY_FACTOR, 32'(decay));
        cfg_write(dtv_pkg::CFG_NOTE_LENGTH, 32'(length));
        cfg_valid <= 1'b0;
    endtask

    // Sender works in bursts; a gap before a burst drops valid
    task automatic send_req(input dtv_pkg::dtv_req_t item);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req       <= item;
        req_valid <= 1'b1;
        do @(posedge clk); while (req_stall);
    endtask

    task automatic drain_results();
        req_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    initial
    begin
        logic [31:0] step;
        logic [15:0] gain;
        logic [23:0] decay;
        logic [23:0] length;
        logic        trig;
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: note length zero, every beat passes through
        send_req(make_req(dtv_pkg::OP_TICK, MIX_MAX, MIX_MIN));
        send_req(make_req(dtv_pkg::OP_TRIGGER, '0, '0));
        send_req(make_req(dtv_pkg::OP_TICK, '1, MIX_MAX));
        drain_results();

        // Full-scale square at half-cycle steps: saturate high and low
        load_voice(32'h8000_0000, dtv_pkg::WAVE_SQUARE, 16'hFFFF, dtv_pkg::ENV_FULL, 24'd4);
        send_req(make_req(dtv_pkg::OP_TRIGGER, MIX_MIN, MIX_MAX));
        send_req(make_req(dtv_pkg::OP_TICK, MIX_MAX, MIX_MAX));
        send_req(make_req(dtv_pkg::OP_TICK, MIX_MIN, MIX_MIN));
        send_req(make_req(dtv_pkg::OP_TICK, MIX_MIN, MIX_MAX));
        send_req(make_req(dtv_pkg::OP_TICK, MIX_MAX, MIX_MIN));
        send_req(make_req(dtv_pkg::OP_TICK, '0, '0));
        drain_results();

        // Triangle, silent gain, zero decay factor, phase wraps every sample
        load_voice('1, dtv_pkg::WAVE_TRIANGLE, 16'h0000, 24'h00_0000, dtv_pkg::ENV_FULL);
        send_req(make_req(dtv_pkg::OP_TRIGGER, '0, '0));
        send_req(make_req(dtv_pkg::OP_TICK, rand_mix(), rand_mix()));
        send_req(make_req(dtv_pkg::OP_TICK, MIX_MAX, MIX_MIN));
        drain_results();

        // Spare waveform code plays as sine, one table entry per sample
        load_voice(32'h0040_0000, WAVE_SPARE, 16'hFFFF, 24'hFF_FFF0, 24'd6);
        send_req(make_req(dtv_pkg::OP_TRIGGER, '0, '0));
        repeat (4) send_req(make_req(dtv_pkg::OP_TICK, rand_mix(), rand_mix()));
        drain_results();

        // Drop note length below the count; spare register index is dropped
        cfg_write(dtv_pkg::CFG_NOTE_LENGTH, '0);
        cfg_write(CFG_SPARE, '1);
        cfg_valid <= 1'b0;
        send_req(make_req(dtv_pkg::OP_TICK, rand_mix(), rand_mix()));
        send_req(make_req(dtv_pkg::OP_TICK, rand_mix(), rand_mix()));
        send_req(make_req(dtv_pkg::OP_TRIGGER, rand_mix(), rand_mix()));
        send_req(make_req(dtv_pkg::OP_TICK, rand_mix(), rand_mix()));
        drain_results();

        load_voice('0, dtv_pkg::WAVE_SINE, 16'd1, 24'd1, 24'd3);
        send_req(make_req(dtv_pkg::OP_TRIGGER, '0, '0));
        send_req(make_req(dtv_pkg::OP_TICK, rand_mix(), rand_mix()));
        send_req(make_req(dtv_pkg::OP_TICK, rand_mix(), rand_mix()));
        drain_results();

        // Random phases: mostly notes started by a trigger, random mix content
        for (int p = 0; p < 12; p++)
        begin
            case ($urandom_range(0, 3))
                0:       step = '0;
                1:       step = '1;
                2:       step = $urandom_range(1, 1 << 22);
                default: step = $urandom();
            endcase
            case ($urandom_range(0, 3))
                0:       gain = '0;
                1:       gain = '1;
                default: gain = $urandom();
            endcase
            case ($urandom_range(0, 3))
                0:       decay = '0;
                1:       decay = '1;
                2:       decay = $urandom();
                default: decay = dtv_pkg::ENV_FULL - 24'($urandom_range(0, 40000));
            endcase
            case ($urandom_range(0, 7))
                0:       length = '0;
                1:       length = '1;
                default: length = $urandom_range(1, 48);
            endcase
            if ($urandom_range(0, 1) == 0)
                cfg_write(IW'($urandom_range(CFG_SPARE, CFG_TOP)), $urandom());
            load_voice(step, 2'($urandom_range(0, 3)), gain, decay, length);
            for (int i = 0; i < 96; i++)
            begin
                // hold off now and then until every result is back
                if ($urandom_range(0, 199) == 0)
                    drain_results();
                trig = (i == 0 && $urandom_range(0, 3) != 0) || $urandom_range(0, 19) == 0;
                send_req(make_req(trig ? dtv_pkg::OP_TRIGGER : dtv_pkg::OP_TICK,
                                  rand_mix(), rand_mix()));
            end
            drain_results();
        end

        repeat (16) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

[files.f]
hdl/dtv_pkg.sv
hdl/dtv_ctrl.sv
hdl/dtv_dp.sv
hdl/decaying_tone_voice_core.sv
hdl/dtv_checker.sv
dv/decaying_tone_voice_core_test.sv
